### design/dqnb_pkg.sv
// shared constants and types for the dns query name blocker
`default_nettype none
package dqnb_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int NAME_MAX_DEF = 256;
  localparam int HDR_LEN      = 12;
  localparam int HDR_PW       = 4;

  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h83;
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_FORWARD = 1'b1;

  typedef struct packed {
    logic                          blocked;
    logic [HDR_LEN-1:0][7:0]       hdr;
  } job_t;

endpackage
`default_nettype wire

### design/dns_query_name_blocker.sv
// top level of the dns query name blocker
//
//   channel  direction  handshake         fields
//   in_      input      in_push/in_full   in_opcode, in_data_byte, in_last
//   out_     output     out_pop/out_empty out_kind, out_reply_byte, out_final_res
//
// load bytes and query bytes are taken one per cycle while the scanner is idle
// the last byte of a query holds intake until its verdict is queued; when a scan
//   runs, each entry looked at takes a length read and check (S_LEN, S_LCHK) and
//   each name byte compared in entries of equal length a byte read and check
//   (S_BYTE, S_BCHK) on the one table read port, then the hand-over in S_PUSH;
//   the scan stops at the first hit; a full verdict queue stretches the hand-over
// blocked replies drain one byte per cycle while popped, via the output register
// reset clears all control state; tables need no clearing pass
`default_nettype none
module dns_query_name_blocker import dqnb_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int NAME_MAX = NAME_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_opcode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_kind,
  output logic [7:0]      out_reply_byte,
  output logic            out_final_res
);

  // verdict transaction between front and back
  job_t f_job, b_job;
  logic f_push, q_full, q_pop, q_empty;

  // parser, loader and scanner
  dqnb_front #(.ENTRIES(ENTRIES), .NAME_MAX(NAME_MAX)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_data_byte, .in_last,
    .job_push(f_push), .job(f_job), .job_full(q_full)
  );

  // decoupling queue
  dqnb_jobq u_jobq (
    .clk, .rst_n, .push(f_push), .wdata(f_job), .full(q_full),
    .pop(q_pop), .rdata(b_job), .empty(q_empty)
  );

  // result generation
  dqnb_back u_back (
    .clk, .rst_n, .job(b_job), .job_empty(q_empty), .job_pop(q_pop),
    .out_empty, .out_pop, .out_kind, .out_reply_byte, .out_final_res
  );

endmodule
`default_nettype wire

### design/dqnb_front.sv
// front end: blocklist loading, query parsing and table scan
`default_nettype none
module dqnb_front import dqnb_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int NAME_MAX = NAME_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_opcode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output logic            job_push,
  output job_t            job,
  input  wire logic       job_full
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = $clog2(NAME_MAX);
  localparam int LW = $clog2(NAME_MAX + 1);
  localparam int TW = $clog2(ENTRIES * NAME_MAX);
  localparam int TD = ENTRIES * NAME_MAX;

  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_LABEL, PH_DONE} phase_t;
  typedef enum logic [2:0] {S_IDLE, S_LEN, S_LCHK, S_BYTE, S_BCHK, S_PUSH} state_t;

  // memories
  logic [7:0]    name_table [TD];
  logic [LW-1:0] entry_lengths [ENTRIES];
  logic [7:0]    name_buffer [NAME_MAX];
  logic [HDR_LEN-1:0][7:0] hdr_r;

  // parse state
  phase_t        phase_r, phase_nxt;
  logic [HDR_PW-1:0] hpos_r, hpos_nxt;
  logic [LW-1:0] nlen_r, nlen_nxt;
  logic [7:0]    lrem_r, lrem_nxt;
  logic          ovf_r, ovf_nxt;

  // load state
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] llen_r;
  logic [TW-1:0] lbase_r;

  // scan state
  state_t        state_r;
  logic [IW-1:0] ent_r;
  logic [PW-1:0] pos_r;
  logic [TW-1:0] sbase_r;
  logic [LW-1:0] slen_r;
  logic          blocked_r;
  logic [LW-1:0] len_q;
  logic [7:0]    tbl_q, nb_q;

  logic          acc, acc_q, acc_l;
  logic          nb_we;
  logic [PW-1:0] nb_wa;
  logic [7:0]    nb_wd;
  logic          scan_go;
  logic          last_ent;

  assign in_full = (state_r != S_IDLE);
  assign acc     = in_push && !in_full;
  assign acc_q   = acc && (in_opcode == OP_QUERY);
  assign acc_l   = acc && (in_opcode == OP_LOAD);

  // next parse state for one query byte
  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    nlen_nxt  = nlen_r;
    lrem_nxt  = lrem_r;
    ovf_nxt   = ovf_r;
    nb_we     = 1'b0;
    nb_wa     = nlen_r[PW-1:0];
    nb_wd     = in_data_byte;
    unique case (phase_r)
      PH_HEADER: begin
        hpos_nxt = hpos_r + HDR_PW'(1);
        if (hpos_r == HDR_PW'(HDR_LEN - 1)) phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (in_data_byte == 8'd0) begin
          phase_nxt = PH_DONE;
        end else begin
          if (nlen_r != '0 || ovf_r) begin
            nb_wd = DOT_CHAR;
            if (nlen_r < LW'(NAME_MAX)) begin
              nb_we    = 1'b1;
              nlen_nxt = nlen_r + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          lrem_nxt  = in_data_byte;
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (nlen_r < LW'(NAME_MAX)) begin
          nb_we    = 1'b1;
          nlen_nxt = nlen_r + LW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        lrem_nxt = lrem_r - 8'd1;
        if (lrem_r == 8'd1) phase_nxt = PH_LENGTH;
      end
      default: ;
    endcase
  end

  // a packet needs a scan only when it carries a usable name
  assign scan_go  = (phase_nxt != PH_HEADER) && !ovf_nxt && (nlen_nxt != '0) &&
                    (cnt_r != '0);
  assign last_ent = (CW'(ent_r) + CW'(1)) == cnt_r;

  always_ff @(posedge clk) begin
    if (acc_q && phase_r == PH_HEADER) hdr_r[hpos_r] <= in_data_byte;
    if (acc_q && nb_we) name_buffer[nb_wa] <= nb_wd;
    if (acc_l && cnt_r < CW'(ENTRIES)) begin
      if (llen_r < LW'(NAME_MAX)) name_table[lbase_r + TW'(llen_r)] <= in_data_byte;
      if (in_last)
        entry_lengths[cnt_r[IW-1:0]] <= llen_r + LW'(llen_r < LW'(NAME_MAX));
    end
    len_q <= entry_lengths[ent_r];
    tbl_q <= name_table[sbase_r + TW'(pos_r)];
    nb_q  <= name_buffer[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hpos_r    <= '0;
      nlen_r    <= '0;
      lrem_r    <= '0;
      ovf_r     <= 1'b0;
      cnt_r     <= '0;
      llen_r    <= '0;
      lbase_r   <= '0;
      state_r   <= S_IDLE;
      ent_r     <= '0;
      pos_r     <= '0;
      sbase_r   <= '0;
      slen_r    <= '0;
      blocked_r <= 1'b0;
    end else begin
      if (acc_l && cnt_r < CW'(ENTRIES)) begin
        if (in_last) begin
          cnt_r   <= cnt_r + CW'(1);
          llen_r  <= '0;
          lbase_r <= lbase_r + TW'(NAME_MAX);
        end else if (llen_r < LW'(NAME_MAX)) begin
          llen_r <= llen_r + LW'(1);
        end
      end
      if (acc_q) begin
        if (in_last) begin
          phase_r <= PH_HEADER;
          hpos_r  <= '0;
          nlen_r  <= '0;
          lrem_r  <= '0;
          ovf_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          hpos_r  <= hpos_nxt;
          nlen_r  <= nlen_nxt;
          lrem_r  <= lrem_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc_q && in_last) begin
            slen_r    <= nlen_nxt;
            ent_r     <= '0;
            sbase_r   <= '0;
            pos_r     <= '0;
            blocked_r <= 1'b0;
            state_r   <= scan_go ? S_LEN : S_PUSH;
          end
        end
        S_LEN: state_r <= S_LCHK;
        S_LCHK: begin
          pos_r <= '0;
          if (len_q == slen_r) begin
            state_r <= S_BYTE;
          end else if (last_ent) begin
            state_r <= S_PUSH;
          end else begin
            ent_r   <= ent_r + IW'(1);
            sbase_r <= sbase_r + TW'(NAME_MAX);
            state_r <= S_LEN;
          end
        end
        S_BYTE: state_r <= S_BCHK;
        S_BCHK: begin
          if (tbl_q != nb_q) begin
            pos_r <= '0;
            if (last_ent) begin
              state_r <= S_PUSH;
            end else begin
              ent_r   <= ent_r + IW'(1);
              sbase_r <= sbase_r + TW'(NAME_MAX);
              state_r <= S_LEN;
            end
          end else if (LW'(pos_r) + LW'(1) == slen_r) begin
            blocked_r <= 1'b1;
            state_r   <= S_PUSH;
          end else begin
            pos_r   <= pos_r + PW'(1);
            state_r <= S_BYTE;
          end
        end
        S_PUSH: if (!job_full) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_push    = (state_r == S_PUSH) && !job_full;
  assign job.blocked = blocked_r;
  assign job.hdr     = hdr_r;

endmodule
`default_nettype wire

### design/dqnb_jobq.sv
// two-entry verdict queue between front and back
`default_nettype none
module dqnb_jobq import dqnb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

### design/dqnb_back.sv
// back end: turns verdicts into reply bytes or a forward verdict
`default_nettype none
module dqnb_back import dqnb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  job_t            job,
  input  wire logic       job_empty,
  output logic            job_pop,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_kind,
  output logic [7:0]      out_reply_byte,
  output logic            out_final_res
);

  job_t              cur_r;
  logic              busy_r, vld_r;
  logic [HDR_PW-1:0] idx_r;
  logic              adv, fin;
  logic [7:0]        byte_sel;

  assign out_empty = !vld_r;
  assign job_pop   = !busy_r && !job_empty;
  assign adv       = busy_r && (!vld_r || out_pop);
  assign fin       = !cur_r.blocked || (idx_r == HDR_PW'(HDR_LEN - 1));

  always_comb begin
    byte_sel = cur_r.hdr[idx_r];
    if (idx_r == HDR_PW'(2)) byte_sel = FLAGS_HI;
    if (idx_r == HDR_PW'(3)) byte_sel = FLAGS_LO;
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur_r <= job;
    if (adv) begin
      out_kind       <= cur_r.blocked ? KIND_REPLY : KIND_FORWARD;
      out_reply_byte <= cur_r.blocked ? byte_sel : 8'd0;
      out_final_res  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (job_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end
      if (adv) begin
        vld_r <= 1'b1;
        idx_r <= idx_r + HDR_PW'(1);
        if (fin) busy_r <= 1'b0;
      end else if (out_pop) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
